// ----- hw/rtl/bed_pkg.sv -----
// Shared types and constants for the button event detector.
`timescale 1ns / 1ps

package bed_pkg;

   // Field widths
   localparam int ELAPSED_W  = 16;
   localparam int HOLD_MS_W  = 16;
   localparam int TIME_W     = 32;
   localparam int HOLD_US_W  = 26;   // 65535 ms * 1000 fits in 26 bits
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_MS      = 1'd1;

   // Reset values
   localparam logic                 ACTIVE_LEVEL_RST = 1'b1;
   localparam logic [HOLD_US_W-1:0] HOLD_US_RST      = 26'd800000;

   // Timing constants in microseconds
   localparam logic [HOLD_US_W-1:0] US_PER_MS     = 26'd1000;
   localparam logic [TIME_W-1:0]    CLICK_MIN_US  = 32'd6000;  // more than 5 whole ms

   typedef struct packed {
      logic                 active_level;
      logic [HOLD_US_W-1:0] hold_us;
   } cfg_type;

   typedef struct packed {
      logic              pressed;
      logic              released;
      logic              actuated;
      logic              held;
      logic [TIME_W-1:0] duration_us;
   } result_type;

endpackage

// ----- hw/rtl/bed_csr.sv -----
// Configuration registers of the button event detector.
`timescale 1ns / 1ps

module bed_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [bed_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bed_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bed_pkg::cfg_type              cfg
);
   import bed_pkg::*;

   logic                 active_level_ff, active_level_in;
   logic [HOLD_US_W-1:0] hold_us_ff, hold_us_in;

   // Decode the write; keep the hold time in microseconds
   always_comb begin
      active_level_in = active_level_ff;
      hold_us_in      = hold_us_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ACTIVE_LEVEL: active_level_in = csr_wdata[0];
            REG_HOLD_MS:      hold_us_in = HOLD_US_W'(csr_wdata[HOLD_MS_W-1:0]) * US_PER_MS;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= ACTIVE_LEVEL_RST;
         hold_us_ff      <= HOLD_US_RST;
      end else begin
         active_level_ff <= active_level_in;
         hold_us_ff      <= hold_us_in;
      end
   end

   assign cfg.active_level = active_level_ff;
   assign cfg.hold_us      = hold_us_ff;

endmodule

// ----- hw/rtl/bed_core.sv -----
// Press timer, report flags and result computation for one pin sample.
`timescale 1ns / 1ps

module bed_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          pin_level,
   input  logic [bed_pkg::ELAPSED_W-1:0] elapsed_us,
   input  bed_pkg::cfg_type              cfg,
   output bed_pkg::result_type           result
);
   import bed_pkg::*;

   logic              running_ff, running_in;
   logic [TIME_W-1:0] press_ff, press_in;
   logic              press_done_ff, press_done_in;
   logic              release_done_ff, release_done_in;
   logic              hold_done_ff, hold_done_in;
   logic              click_done_ff, click_done_in;
   logic              length_done_ff, length_done_in;

   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] acc;
   logic              restart;
   logic              below_hold;

   // Saturating accumulate while the timer runs
   assign sum = {1'b0, press_ff} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, elapsed_us};
   always_comb begin
      acc = press_ff;
      if (running_ff) begin
         acc = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      end
   end

   assign restart = (pin_level == cfg.active_level) && !running_ff;

   // Next timer state and the report flags
   always_comb begin
      logic pd, rd, hd, cd, ld;
      pd = press_done_ff;
      rd = release_done_ff;
      hd = hold_done_ff;
      cd = click_done_ff;
      ld = length_done_ff;
      press_in   = restart ? '0 : acc;
      running_in = (pin_level == cfg.active_level);
      if (restart) begin
         pd = 1'b0;
         rd = 1'b0;
         hd = 1'b0;
         cd = 1'b0;
         ld = 1'b0;
      end
      below_hold = press_in < TIME_W'(cfg.hold_us);

      result.pressed     = !pd && running_in;
      result.released    = !rd && !running_in;
      result.actuated    = !cd && !running_in && (press_in >= CLICK_MIN_US) && below_hold;
      result.held        = !hd && running_in && !below_hold;
      result.duration_us = (!running_in && ld) ? '0 : press_in;

      press_done_in   = pd | result.pressed;
      release_done_in = rd | result.released;
      click_done_in   = cd | result.actuated;
      hold_done_in    = hd | result.held;
      length_done_in  = ld | !running_in;
   end

   // Commit state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         press_ff        <= '0;
         press_done_ff   <= 1'b0;
         release_done_ff <= 1'b1;
         hold_done_ff    <= 1'b0;
         click_done_ff   <= 1'b0;
         length_done_ff  <= 1'b0;
      end else if (step) begin
         running_ff      <= running_in;
         press_ff        <= press_in;
         press_done_ff   <= press_done_in;
         release_done_ff <= release_done_in;
         hold_done_ff    <= hold_done_in;
         click_done_ff   <= click_done_in;
         length_done_ff  <= length_done_in;
      end
   end

`ifndef SYNTH
   // A running press count never goes down on the next item
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (step && running_ff) |=> (press_ff >= $past(press_ff)))
      else $error("press count decreased while timer ran");

   // A stopped timer keeps its count
   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      (step && !running_ff && pin_level != cfg.active_level) |=> $stable(press_ff))
      else $error("press count changed while timer stopped");

   // Pressed is reported only for a running timer
   a_pressed_running: assert property (@(posedge clock) disable iff (reset)
      (step && result.pressed) |=> (running_ff && press_done_ff))
      else $error("pressed reported without running timer");
`endif

endmodule

// ----- hw/rtl/button_event_detector.sv -----
// Top level of the button event detector: input register, core and result register.
`timescale 1ns / 1ps

// Button event detector. Each transfer on req_ carries one pin sample and the
// microseconds since the previous sample; each yields exactly one result on rsp_
// with the pressed, released, actuated and held flags and the press duration.
// One sample is taken every clock cycle unless the result register is stalled; a
// result passes through the input register, then the result register, and the only
// loop is the update of the press timer and flags. Configuration writes on csr_
// (index 0: active pin level, index 1: hold time in ms) are always ready and
// take effect on the next cycle; issue them only while no sample is in flight.
module button_event_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_pin_level,
   input  logic [bed_pkg::ELAPSED_W-1:0]  req_elapsed_us,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pressed,
   output logic                           rsp_released,
   output logic                           rsp_actuated,
   output logic                           rsp_held,
   output logic [bed_pkg::TIME_W-1:0]     rsp_duration_us,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bed_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bed_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bed_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic                 in_vld_ff, in_vld_in;
   logic                 in_pin_ff;
   logic [ELAPSED_W-1:0] in_elapsed_ff;
   logic                 out_vld_ff, out_vld_in;
   result_type           out_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   assign csr_ready = 1'b1;

   bed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: move an item forward when the result register frees up
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = out_free ? in_vld_ff : out_vld_ff;

   bed_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pin_level  (in_pin_ff),
      .elapsed_us (in_elapsed_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff     <= req_pin_level;
         in_elapsed_ff <= req_elapsed_us;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_pressed     = out_ff.pressed;
   assign rsp_released    = out_ff.released;
   assign rsp_actuated    = out_ff.actuated;
   assign rsp_held        = out_ff.held;
   assign rsp_duration_us = out_ff.duration_us;

`ifndef SYNTH
   // Pressed and released never come together
   a_press_xor_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pressed && rsp_released))
      else $error("pressed and released in one result");

   // A click is reported only with the timer stopped
   a_click_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_actuated) |-> !(rsp_pressed || rsp_held))
      else $error("actuated reported with a running press");

   // Held is reported only while the press runs
   a_held_not_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_held) |-> !rsp_released)
      else $error("held reported with release");
`endif

endmodule
